### rtl/i2c_master_byte_controller_unit_defines.svh
// assertion macros shared by the rtl
`ifndef I2C_MASTER_BYTE_CONTROLLER_UNIT_DEFINES_SVH
`define I2C_MASTER_BYTE_CONTROLLER_UNIT_DEFINES_SVH

// property checked on every clock edge outside reset
`define I2CMBC_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// condition in one cycle implies consequence in the next
`define I2CMBC_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/i2cmbc_pkg.sv
package i2cmbc_pkg;

  // configuration
  localparam int unsigned HalfPeriodW = 16;
  localparam logic [HalfPeriodW-1:0] HalfPeriodRst = 16'd4;
  localparam int unsigned ApbAddrW = 3;
  localparam logic RegIdxHalfPeriod = 1'b0;

  // msb select mask for byte shifting
  localparam logic [7:0] MsbMask = 8'h80;

  // bus commands
  typedef enum logic [1:0] {
    CMD_START = 2'd0,
    CMD_STOP  = 2'd1,
    CMD_WRITE = 2'd2,
    CMD_READ  = 2'd3
  } cmd_e;

  // sequencer phases, one-hot
  typedef enum logic [14:0] {
    PH_IDLE   = 15'h0001,
    PH_S_SCLH = 15'h0002,
    PH_S_SDAL = 15'h0004,
    PH_S_END  = 15'h0008,
    PH_P_SCLH = 15'h0010,
    PH_P_SDAH = 15'h0020,
    PH_P_END  = 15'h0040,
    PH_W_HI   = 15'h0080,
    PH_W_LO   = 15'h0100,
    PH_W_AH   = 15'h0200,
    PH_W_END  = 15'h0400,
    PH_R_HI   = 15'h0800,
    PH_R_LO   = 15'h1000,
    PH_R_AH   = 15'h2000,
    PH_R_END  = 15'h4000
  } phase_e;

  // input item
  typedef struct packed {
    logic       cmd_valid;
    logic [1:0] req_type;
    logic [7:0] write_byte;
    logic       ack_to_send;
    logic       sda_in;
  } in_item_t;

  // result item
  typedef struct packed {
    logic       scl_out;
    logic       sda_out;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_byte;
    logic       ack_seen;
  } out_item_t;

  // controller state
  typedef struct packed {
    phase_e                 phase;
    logic [HalfPeriodW-1:0] wait_count;
    logic [3:0]             bit_index;
    logic [7:0]             shift_byte;
    logic                   pending_ack;
    logic                   scl_level;
    logic                   sda_level;
    logic [7:0]             last_read;
    logic                   last_ack;
  } state_t;

  localparam state_t StateRst = '{
    phase:       PH_IDLE,
    wait_count:  '0,
    bit_index:   '0,
    shift_byte:  '0,
    pending_ack: 1'b1,
    scl_level:   1'b1,
    sda_level:   1'b1,
    last_read:   '0,
    last_ack:    1'b1
  };

  // bit of a byte at msb-first position
  function automatic logic tx_bit(logic [7:0] data, logic [2:0] idx);
    logic [7:0] mask;
    mask = MsbMask >> idx;
    return |(data & mask);
  endfunction

endpackage

### rtl/i2cmbc_regs.sv
module i2cmbc_regs (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [i2cmbc_pkg::ApbAddrW-1:0]     paddr,
  input  logic [31:0]                         pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready,
  output logic [i2cmbc_pkg::HalfPeriodW-1:0]  half_period_o
);
  import i2cmbc_pkg::*;

  logic [HalfPeriodW-1:0] half_period_q;
  logic                   wr_en;
  logic                   sel_half_period;

  // address decode
  assign sel_half_period = (paddr[ApbAddrW-1] == RegIdxHalfPeriod);
  assign wr_en           = psel && penable && pwrite;

  // register write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_period_q <= HalfPeriodRst;
    end else if (wr_en && sel_half_period) begin
      half_period_q <= pwdata[HalfPeriodW-1:0];
    end
  end

  // read back
  always_comb begin
    prdata = '0;
    if (sel_half_period) begin
      prdata = {{(32-HalfPeriodW){1'b0}}, half_period_q};
    end
  end

  assign pready        = 1'b1;
  assign half_period_o = half_period_q;

endmodule

### rtl/i2cmbc_step.sv
module i2cmbc_step (
  input  i2cmbc_pkg::state_t                  st_i,
  input  i2cmbc_pkg::in_item_t                item_i,
  input  logic [i2cmbc_pkg::HalfPeriodW-1:0]  half_period_i,
  output i2cmbc_pkg::state_t                  st_o,
  output i2cmbc_pkg::out_item_t               res_o
);
  import i2cmbc_pkg::*;

  state_t                 st;
  logic                   done;
  logic [HalfPeriodW-1:0] wait_arm;
  logic [HalfPeriodW-1:0] wait_dec;
  logic [3:0]             bit_nxt;
  logic [7:0]             rd_mask;

  // zero half period counts as one tick
  assign wait_arm = (half_period_i == '0) ? {{(HalfPeriodW-1){1'b0}}, 1'b1} : half_period_i;
  assign wait_dec = (st_i.wait_count != '0) ? st_i.wait_count - 1'b1 : '0;
  assign bit_nxt  = st_i.bit_index + 4'd1;
  assign rd_mask  = MsbMask >> st_i.bit_index[2:0];

  // one tick of the sequencer
  always_comb begin
    st   = st_i;
    done = 1'b0;
    if (st_i.phase == PH_IDLE) begin
      // command launch, first pin change in the same tick
      if (item_i.cmd_valid) begin
        st.bit_index  = '0;
        st.wait_count = wait_arm;
        unique case (item_i.req_type)
          CMD_START: begin
            st.scl_level = 1'b0;
            st.sda_level = 1'b1;
            st.phase     = PH_S_SCLH;
          end
          CMD_STOP: begin
            st.scl_level = 1'b0;
            st.sda_level = 1'b0;
            st.phase     = PH_P_SCLH;
          end
          CMD_WRITE: begin
            st.shift_byte = item_i.write_byte;
            st.sda_level  = item_i.write_byte[7];
            st.phase      = PH_W_HI;
          end
          CMD_READ: begin
            st.shift_byte  = '0;
            st.pending_ack = item_i.ack_to_send;
            st.sda_level   = 1'b1;
            st.phase       = PH_R_HI;
          end
        endcase
      end
    end else begin
      st.wait_count = wait_dec;
      if (wait_dec == '0) begin
        st.wait_count = wait_arm;
        unique case (st_i.phase) inside
          PH_S_SCLH: begin
            st.scl_level = 1'b1;
            st.phase     = PH_S_SDAL;
          end
          PH_S_SDAL: begin
            st.sda_level = 1'b0;
            st.phase     = PH_S_END;
          end
          PH_P_SCLH: begin
            st.scl_level = 1'b1;
            st.phase     = PH_P_SDAH;
          end
          PH_P_SDAH: begin
            st.sda_level = 1'b1;
            st.phase     = PH_P_END;
          end
          PH_W_HI: begin
            st.scl_level = 1'b1;
            st.phase     = PH_W_LO;
          end
          PH_W_LO: begin
            st.scl_level = 1'b0;
            st.bit_index = bit_nxt;
            if (!bit_nxt[3]) begin
              st.sda_level = tx_bit(st_i.shift_byte, bit_nxt[2:0]);
              st.phase     = PH_W_HI;
            end else begin
              st.sda_level = 1'b1;
              st.phase     = PH_W_AH;
            end
          end
          PH_W_AH: begin
            st.scl_level = 1'b1;
            st.last_ack  = item_i.sda_in;
            st.phase     = PH_W_END;
          end
          PH_R_HI: begin
            st.scl_level = 1'b1;
            if (item_i.sda_in) begin
              st.shift_byte = st_i.shift_byte | rd_mask;
            end else begin
              st.shift_byte = st_i.shift_byte & ~rd_mask;
            end
            st.phase = PH_R_LO;
          end
          PH_R_LO: begin
            st.scl_level = 1'b0;
            st.bit_index = bit_nxt;
            if (!bit_nxt[3]) begin
              st.phase = PH_R_HI;
            end else begin
              st.last_read = st_i.shift_byte;
              st.sda_level = st_i.pending_ack;
              st.phase     = PH_R_AH;
            end
          end
          PH_R_AH: begin
            st.scl_level = 1'b1;
            st.phase     = PH_R_END;
          end
          PH_S_END, PH_P_END, PH_W_END, PH_R_END: begin
            st.scl_level  = 1'b0;
            st.phase      = PH_IDLE;
            st.wait_count = '0;
            done          = 1'b1;
          end
          default: begin
            st.phase      = PH_IDLE;
            st.wait_count = '0;
          end
        endcase
      end
    end
  end

  // result fields reflect the state after the tick
  assign st_o               = st;
  assign res_o.scl_out      = st.scl_level;
  assign res_o.sda_out      = st.sda_level;
  assign res_o.busy_res     = (st.phase != PH_IDLE);
  assign res_o.done_res     = done;
  assign res_o.read_byte    = st.last_read;
  assign res_o.ack_seen     = st.last_ack;

endmodule

### rtl/i2c_master_byte_controller_unit.sv
// I2C master byte controller. Each input item is one tick of the bus
// sequencer: the sampled SDA level plus an optional start, stop, write or
// read command, taken only while no sequence runs. Each item yields exactly
// one result item with the SCL/SDA drive levels, busy, a done pulse, the last
// byte read and the last acknowledge sampled.
// Both channels use valid/ready. An accepted item is held in an input
// register, processed by the sequencer step logic, and its result lands in
// an output register, so the result is shown once it has passed both
// registers; one item is taken every cycle unless the receiver stalls.
// The wait between pin changes comes from the half period register
// (APB, offset 0, 16 bits, reset value 4); write it only while idle.
// When the receiver stalls, the result is held, the sequencer state is
// frozen and the held input item fills the input register; in_ready_o
// drops once that register is full. Reset empties both registers, releases
// SCL and SDA and returns the sequencer to idle.
`include "i2c_master_byte_controller_unit_defines.svh"

module i2c_master_byte_controller_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  i2cmbc_pkg::in_item_t                in_item_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output i2cmbc_pkg::out_item_t               out_item_o,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [i2cmbc_pkg::ApbAddrW-1:0]     paddr,
  input  logic [31:0]                         pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready
);
  import i2cmbc_pkg::*;

  logic                   in_valid_q;
  in_item_t               in_q;
  state_t                 state_q;
  state_t                 st_d;
  out_item_t              res;
  logic                   out_valid_q;
  out_item_t              out_q;
  logic                   adv;
  logic [HalfPeriodW-1:0] half_period;

  // configuration registers
  i2cmbc_regs u_regs (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .half_period_o (half_period)
  );

  // item advances when the output slot is free or being drained
  assign adv        = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || adv;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q <= in_item_i;
    end
  end

  // sequencer step
  i2cmbc_step u_step (
    .st_i          (state_q),
    .item_i        (in_q),
    .half_period_i (half_period),
    .st_o          (st_d),
    .res_o         (res)
  );

  // sequencer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StateRst;
    end else if (adv) begin
      state_q <= st_d;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // checks
  `I2CMBC_ASSERT(a_done_not_busy, out_valid_q && out_q.done_res |-> !out_q.busy_res, "done while busy")
  `I2CMBC_ASSERT(a_done_from_busy, adv && res.done_res |-> state_q.phase != PH_IDLE, "done from idle")
  `I2CMBC_ASSERT_NXT(a_state_hold, !adv, $stable(state_q), "state moved without an item")
  `I2CMBC_ASSERT_NXT(a_in_hold, in_valid_q && !adv, in_valid_q && $stable(in_q), "held item lost")

endmodule
